[design/ide_pkg.sv]
// Shared types and constants for the indexed deque engine.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package ide_pkg;

  localparam int DEPTH  = 256;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = ADDR_W + 1;

  // request kinds
  localparam logic [2:0] K_PUSH_FRONT = 3'd0;
  localparam logic [2:0] K_PUSH_BACK  = 3'd1;
  localparam logic [2:0] K_POP_FRONT  = 3'd2;
  localparam logic [2:0] K_POP_BACK   = 3'd3;
  localparam logic [2:0] K_READ_IDX   = 3'd4;
  localparam logic [2:0] K_WRITE_IDX  = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_BOUND = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [2:0]          kind;
    logic signed [31:0]  data_value;
    logic [7:0]          position;
  } ide_in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic signed [31:0]  result_value;
    logic [8:0]          occupancy;
  } ide_out_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic execute;
    logic load;
  } ide_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } ide_stat_t;

endpackage

[design/ide_ctrl.sv]
// Controller for the indexed deque engine: sequences capture, execute, load.
// Depends on ide_pkg.
`timescale 1ns / 1ps

module ide_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output ide_pkg::ide_cmd_t  cmd,
  input  ide_pkg::ide_stat_t stat
);
  import ide_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_stall    = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.execute = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        // wait for the output register to free up
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_exec_follows_capture: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.execute)
    else $error("execute did not follow capture");

  a_fin_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> (state_r == S_FIN) && in_stall)
    else $error("finish step missing after execute");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !cmd.capture)
    else $error("capture while busy");

endmodule

[design/ide_datapath.sv]
// Datapath for the indexed deque engine: request regs, ring store,
// front/count registers and output register. Depends on ide_pkg.
`timescale 1ns / 1ps

module ide_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  ide_pkg::ide_in_t    in_data,
  input  ide_pkg::ide_cmd_t   cmd,
  output ide_pkg::ide_stat_t  stat,
  output logic                out_valid,
  input  logic                out_stall,
  output ide_pkg::ide_out_t   out_data
);
  import ide_pkg::*;

  logic [2:0]          kind_r;
  logic signed [31:0]  value_r;
  logic [7:0]          pos_r;

  logic [ADDR_W-1:0]   front_r, front_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;

  logic [31:0]         mem [DEPTH];
  logic [31:0]         rdata_r;

  logic [1:0]          status_r;
  logic                rd_flag_r;

  logic                out_valid_r, out_valid_nxt;
  ide_out_t            out_data_r;

  // execute-step decode
  logic [1:0]          st_c;
  logic                we_c, re_c;
  logic [SUM_W-1:0]    lg_c, sum_c, wrap_c;
  logic [ADDR_W-1:0]   addr_c;
  logic                full_c, empty_c, oob_c;

  assign full_c  = (count_r == CNT_W'(DEPTH));
  assign empty_c = (count_r == '0);
  assign oob_c   = (32'(pos_r) >= 32'(count_r));

  always_comb begin
    st_c      = ST_OK;
    we_c      = 1'b0;
    re_c      = 1'b0;
    lg_c      = '0;
    front_nxt = front_r;
    count_nxt = count_r;
    unique case (kind_r)
      K_PUSH_FRONT: begin
        lg_c = SUM_W'(DEPTH - 1);
        if (full_c) begin
          st_c = ST_FULL;
        end else begin
          we_c      = 1'b1;
          front_nxt = addr_c;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      K_PUSH_BACK: begin
        lg_c = SUM_W'(count_r);
        if (full_c) begin
          st_c = ST_FULL;
        end else begin
          we_c      = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      K_POP_FRONT: begin
        lg_c = SUM_W'(1);
        if (empty_c) begin
          st_c = ST_EMPTY;
        end else begin
          re_c      = 1'b1;
          front_nxt = addr_c;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      K_POP_BACK: begin
        lg_c = SUM_W'(count_r - CNT_W'(1));
        if (empty_c) begin
          st_c = ST_EMPTY;
        end else begin
          re_c      = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      K_READ_IDX: begin
        lg_c = SUM_W'(pos_r);
        if (oob_c) begin
          st_c = ST_BOUND;
        end else begin
          re_c = 1'b1;
        end
      end
      K_WRITE_IDX: begin
        lg_c = SUM_W'(pos_r);
        if (oob_c) begin
          st_c = ST_BOUND;
        end else begin
          we_c = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // ring slot of the selected logical index
  assign sum_c  = SUM_W'(front_r) + lg_c;
  assign wrap_c = (sum_c >= SUM_W'(DEPTH)) ? sum_c - SUM_W'(DEPTH) : sum_c;

  // pop front reads the current front, not the advanced one
  logic [ADDR_W-1:0] mem_addr_c;
  assign addr_c     = ADDR_W'(wrap_c);
  assign mem_addr_c = (kind_r == K_POP_FRONT) ? front_r : addr_c;

  always_ff @(posedge clk) begin
    if (cmd.execute && we_c) begin
      mem[mem_addr_c] <= value_r;
    end
    if (cmd.execute && re_c) begin
      rdata_r <= mem[mem_addr_c];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= in_data.kind;
      value_r <= in_data.data_value;
      pos_r   <= in_data.position;
    end
    if (cmd.execute) begin
      status_r  <= st_c;
      rd_flag_r <= re_c;
    end
    if (cmd.load) begin
      out_data_r.status       <= status_r;
      out_data_r.result_value <= rd_flag_r ? rdata_r : 32'sd0;
      out_data_r.occupancy    <= 9'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.execute) begin
        front_r <= front_nxt;
        count_r <= count_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign stat.out_free = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("element count above depth");

  a_refused_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute && (st_c != ST_OK) |=> $stable(count_r) && $stable(front_r))
    else $error("refused request changed state");

  a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute && re_c && (kind_r == K_POP_FRONT || kind_r == K_POP_BACK)
    |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("pop did not decrement count");

  a_no_rw_both: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |-> !(we_c && re_c))
    else $error("read and write in one request");

endmodule

[design/indexed_deque_engine_top.sv]
// Indexed deque engine: bounded double-ended queue with access by index.
// Result is registered through execute and load; load waits for a free output.
// The controller runs capture, execute (one ring-store access), load in turn,
// one request at a time; in_stall stays high until the load step is done.
// Reset (sync, active low) clears front, count and valids; store is not cleared.
`timescale 1ns / 1ps

module indexed_deque_engine_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ide_pkg::ide_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ide_pkg::ide_out_t out_data
);
  import ide_pkg::*;

  ide_cmd_t  cmd;
  ide_stat_t stat;

  ide_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  ide_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[bench/tb_indexed_deque_engine_top.sv]
// Self-checking bench for indexed_deque_engine_top. It sends deque requests with random gaps
// and output back-pressure, predicts every result with its own ring model, and checks each one.
// Depends on ide_pkg and the indexed_deque_engine_top RTL.
`timescale 1ns / 1ps

module tb_indexed_deque_engine_top;
  import ide_pkg::*;

  // kind codes the block ignores
  localparam logic [2:0] K_SPARE_6 = 3'd6;
  localparam logic [2:0] K_SPARE_7 = 3'd7;

  localparam int MAX_GAP       = 12;
  localparam int QUIET_LIMIT   = 4000;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int PRESSURE_HOLD = 300;
  localparam int SEG_ITEMS     = 100;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  ide_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ide_out_t out_data;

  // deque state as the bench sees it
  logic signed [31:0] ring_mem [DEPTH];
  logic [ADDR_W-1:0]  ring_front = '0;
  logic [CNT_W-1:0]   ring_count = '0;
  ide_out_t           expected_results [$];

  bit in_idle_en  = 1'b1;
  bit out_idle_en = 1'b1;
  int hold_req    = 0;
  int err_cnt     = 0;
  int sent_cnt    = 0;
  int checked_cnt = 0;
  int peak_count  = 0;
  int status_seen [4] = '{default: 0};

  indexed_deque_engine_top dut (
    .clk,
    .rst_n,
    .in_valid,
    .in_stall,
    .in_data,
    .out_valid,
    .out_stall,
    .out_data
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Applies one request to the bench's deque and returns the result it must produce.
  function automatic ide_out_t deque_predict(input ide_in_t req);
    ide_out_t          rsp;
    logic [ADDR_W-1:0] slot;
    rsp = '0;
    rsp.status = ST_OK;
    case (req.kind)
      K_PUSH_FRONT, K_PUSH_BACK: begin
        if (ring_count >= DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          if (req.kind == K_PUSH_FRONT) begin
            ring_front = ring_front - ADDR_W'(1);
            slot = ring_front;
          end else begin
            slot = ring_front + ring_count[ADDR_W-1:0];
          end
          ring_mem[slot] = req.data_value;
          ring_count = ring_count + CNT_W'(1);
        end
      end
      K_POP_FRONT, K_POP_BACK: begin
        if (ring_count == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          if (req.kind == K_POP_FRONT) begin
            slot = ring_front;
            ring_front = ring_front + ADDR_W'(1);
          end else begin
            slot = ring_front + ring_count[ADDR_W-1:0] - ADDR_W'(1);
          end
          rsp.result_value = ring_mem[slot];
          ring_count = ring_count - CNT_W'(1);
        end
      end
      K_READ_IDX, K_WRITE_IDX: begin
        if (req.position >= ring_count) begin
          rsp.status = ST_BOUND;
        end else begin
          slot = ring_front + req.position;
          if (req.kind == K_READ_IDX) begin
            rsp.result_value = ring_mem[slot];
          end else begin
            ring_mem[slot] = req.data_value;
          end
        end
      end
      default: begin
      end
    endcase
    rsp.occupancy = ring_count;
    return rsp;
  endfunction

  function automatic ide_in_t mk_req(input logic [2:0] kind, input logic signed [31:0] value,
                                     input logic [7:0] pos);
    ide_in_t req;
    req.kind       = kind;
    req.data_value = value;
    req.position   = pos;
    return req;
  endfunction

  // Mostly well-formed requests: index inside the current occupancy, push share set by caller.
  function automatic ide_in_t rand_req(input int push_pct);
    ide_in_t req;
    int      roll;
    req = '0;
    case ($urandom_range(0, 11))
      0:       req.data_value = 32'sh7FFF_FFFF;
      1:       req.data_value = 32'sh8000_0000;
      2:       req.data_value = '0;
      3:       req.data_value = '1;
      default: req.data_value = $urandom;
    endcase
    if (ring_count != 0 && $urandom_range(0, 99) < 85) begin
      req.position = 8'($urandom_range(0, ring_count - 1));
    end else begin
      req.position = 8'($urandom_range(0, 255));
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      req.kind = 3'($urandom_range(0, 7));
    end else if (roll < push_pct) begin
      req.kind = $urandom_range(0, 1) ? K_PUSH_FRONT : K_PUSH_BACK;
    end else if (roll < push_pct + (100 - push_pct) / 2) begin
      req.kind = $urandom_range(0, 1) ? K_POP_FRONT : K_POP_BACK;
    end else begin
      req.kind = $urandom_range(0, 1) ? K_READ_IDX : K_WRITE_IDX;
    end
    return req;
  endfunction

  // One input transfer; the expectation is queued once the request has been taken.
  task automatic send_req(input ide_in_t req);
    int       gap;
    ide_out_t rsp;
    gap = in_idle_en ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rsp = deque_predict(req);
    expected_results.push_back(rsp);
    status_seen[rsp.status]++;
    sent_cnt++;
    if (ring_count > peak_count) peak_count = int'(ring_count);
  endtask

  task automatic wait_drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic test_empty_refusals();
    send_req(mk_req(K_POP_FRONT, $urandom, 8'd0));
    send_req(mk_req(K_POP_BACK, $urandom, 8'd0));
    send_req(mk_req(K_READ_IDX, $urandom, 8'd0));
    send_req(mk_req(K_WRITE_IDX, $urandom, 8'd255));
  endtask

  task automatic test_directed_basics();
    send_req(mk_req(K_PUSH_FRONT, 32'sh7FFF_FFFF, 8'd0));
    send_req(mk_req(K_PUSH_BACK, 32'sh8000_0000, 8'd255));
    send_req(mk_req(K_PUSH_FRONT, -32'sd1, 8'd0));
    send_req(mk_req(K_PUSH_BACK, 32'sd0, 8'd0));
    send_req(mk_req(K_READ_IDX, $urandom, 8'd0));
    send_req(mk_req(K_READ_IDX, $urandom, 8'd3));
    send_req(mk_req(K_READ_IDX, $urandom, 8'd4));
    send_req(mk_req(K_READ_IDX, $urandom, 8'd255));
    send_req(mk_req(K_WRITE_IDX, 32'sh5A5A_A5A5, 8'd2));
    send_req(mk_req(K_READ_IDX, $urandom, 8'd2));
    send_req(mk_req(K_WRITE_IDX, $urandom, 8'd4));
    send_req(mk_req(K_SPARE_6, 32'sh7FFF_FFFF, 8'd255));
    send_req(mk_req(K_SPARE_7, 32'sh8000_0000, 8'd0));
    send_req(mk_req(K_POP_FRONT, $urandom, 8'd0));
    send_req(mk_req(K_POP_BACK, $urandom, 8'd0));
    send_req(mk_req(K_POP_BACK, $urandom, 8'd0));
    // last element leaves: deque must come back empty
    send_req(mk_req(K_POP_FRONT, $urandom, 8'd0));
    send_req(mk_req(K_POP_BACK, $urandom, 8'd0));
    send_req(mk_req(K_PUSH_BACK, 32'sh1234_5678, 8'd0));
    send_req(mk_req(K_READ_IDX, $urandom, 8'd0));
    send_req(mk_req(K_POP_FRONT, $urandom, 8'd0));
  endtask

  // Fill every slot, hit the refused pushes and the top index, then empty it again.
  task automatic test_full_ring();
    repeat (DEPTH) begin
      send_req(mk_req($urandom_range(0, 1) ? K_PUSH_FRONT : K_PUSH_BACK, $urandom,
                      8'($urandom)));
    end
    send_req(mk_req(K_PUSH_FRONT, $urandom, 8'd0));
    send_req(mk_req(K_PUSH_BACK, $urandom, 8'd0));
    send_req(mk_req(K_READ_IDX, $urandom, 8'd255));
    send_req(mk_req(K_WRITE_IDX, $urandom, 8'd255));
    send_req(mk_req(K_READ_IDX, $urandom, 8'd255));
    send_req(mk_req(K_READ_IDX, $urandom, 8'd0));
    repeat (DEPTH) begin
      send_req(mk_req($urandom_range(0, 1) ? K_POP_FRONT : K_POP_BACK, $urandom,
                      8'($urandom)));
    end
    send_req(mk_req(K_POP_FRONT, $urandom, 8'd0));
  endtask

  // Receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    hold_req   = PRESSURE_HOLD;
    in_idle_en = 1'b0;
    repeat (40) send_req(rand_req(60));
    in_idle_en = 1'b1;
  endtask

  task automatic test_random_mix();
    int push_share [6] = '{70, 70, 25, 70, 65, 20};
    for (int seg = 0; seg < 6; seg++) begin
      in_idle_en  = (seg != 2);
      out_idle_en = (seg != 2) && (seg != 4);
      repeat (SEG_ITEMS) send_req(rand_req(push_share[seg]));
    end
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
  endtask

  always @(posedge clk) begin : result_check
    ide_out_t exp_rsp;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: status %0d value %0d occupancy %0d",
               out_data.status, out_data.result_value, out_data.occupancy);
        err_cnt++;
      end else begin
        exp_rsp = expected_results.pop_front();
        checked_cnt++;
        if (out_data.status !== exp_rsp.status) begin
          $error("status mismatch: expected %0d, actual %0d", exp_rsp.status,
                 out_data.status);
          err_cnt++;
        end
        if (out_data.result_value !== exp_rsp.result_value) begin
          $error("result_value mismatch: expected %0d, actual %0d", exp_rsp.result_value,
                 out_data.result_value);
          err_cnt++;
        end
        if (out_data.occupancy !== exp_rsp.occupancy) begin
          $error("occupancy mismatch: expected %0d, actual %0d", exp_rsp.occupancy,
                 out_data.occupancy);
          err_cnt++;
        end
      end
    end
  end

  // Result side stall: random per transfer, or one long hold when asked.
  initial begin : result_receiver
    int n;
    forever begin
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end else begin
        n = out_idle_en ? $urandom_range(0, MAX_GAP) : 0;
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid && hold_req == 0);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("no transfer for %0d cycles", QUIET_LIMIT);
    $display("** indexed_deque_engine_top: FAILED **");
    $finish;
  end

  initial begin : test_sequence
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_refusals();
    test_directed_basics();
    wait_drain();
    test_full_ring();
    wait_drain();
    test_backpressure();
    wait_drain();
    test_random_mix();
    wait_drain();
    // let any stray result show up before closing
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      err_cnt++;
    end
    $display("Run drove %0d requests, checked %0d results, peak occupancy %0d.",
             sent_cnt, checked_cnt, peak_count);
    $display("Refused requests: %0d pops on empty, %0d index out of bound, %0d pushes on full.",
             status_seen[ST_EMPTY], status_seen[ST_BOUND], status_seen[ST_FULL]);
    if (err_cnt == 0) begin
      $display("** indexed_deque_engine_top: PASSED **");
    end else begin
      $display("** indexed_deque_engine_top: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
design/ide_pkg.sv
design/ide_ctrl.sv
design/ide_datapath.sv
design/indexed_deque_engine_top.sv
bench/tb_indexed_deque_engine_top.sv
